@@ sv/htlp_pkg.sv @@
`timescale 1ns / 1ps

package htlp_pkg;

  // Table geometry. The home slot is the low hash bits, so the depth is a power of two.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH - 1);

  // FNV-1a style, 64 bit, with a nonstandard basis. Prime = 2^40 + 0x1B3.
  localparam logic [63:0] FNV_BASIS     = 64'd1469598103934665603;
  localparam int          FNV_PRIME_SHL = 40;
  localparam logic [8:0]  FNV_PRIME_LO  = 9'h1B3;

  // Request kinds
  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  // Result codes
  localparam logic [1:0] STS_ABSENT = 2'd0;
  localparam logic [1:0] STS_HIT    = 2'd1;
  localparam logic [1:0] STS_NEW    = 2'd2;
  localparam logic [1:0] STS_FULL   = 2'd3;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_OCC   = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

  typedef struct packed {
    slot_st_t    st;
    logic [63:0] key;
    logic [63:0] val;
  } slot_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      read_value;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LOOK,
    S_CHECK
  } state_t;

  // Keep bytes up to the first zero byte, clear the rest.
  function automatic logic [63:0] as_str(input logic [63:0] x);
    logic [63:0] r;
    logic        live;
    r    = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (x[8*b +: 8] == 8'h00) live = 1'b0;
      if (live) r[8*b +: 8] = x[8*b +: 8];
    end
    return r;
  endfunction

  // One FNV-1a byte step: xor then multiply by the prime (shift plus small constant product).
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << FNV_PRIME_SHL) + (x * {55'd0, FNV_PRIME_LO});
  endfunction

endpackage

@@ sv/htlp_ram.sv @@
`timescale 1ns / 1ps

module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/htlp_fnv.sv @@
`timescale 1ns / 1ps

// Iterative FNV-1a: one key byte per cycle, stops at the first zero byte.
module htlp_fnv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      kick,
  input  logic [63:0]               key,
  output logic                      done,
  output logic [htlp_pkg::IDX_W-1:0] slot
);
  import htlp_pkg::*;

  logic        run_r, run_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] ks_r, ks_nxt;

  assign done = run_r && (ks_r[7:0] == 8'h00);
  assign slot = h_r[IDX_W-1:0];

  always_comb begin
    run_nxt = run_r;
    h_nxt   = h_r;
    ks_nxt  = ks_r;
    if (kick) begin
      run_nxt = 1'b1;
      h_nxt   = FNV_BASIS;
      ks_nxt  = key;
    end else if (run_r) begin
      if (ks_r[7:0] == 8'h00) begin
        run_nxt = 1'b0;
      end else begin
        h_nxt  = fnv_step(h_r, ks_r[7:0]);
        ks_nxt = ks_r >> 8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    h_r  <= h_nxt;
    ks_r <= ks_nxt;
  end

endmodule

@@ sv/hash_table_linear_probe_top.sv @@
`timescale 1ns / 1ps

// Channel | Ports                        | Handshake
// --------+------------------------------+------------------------------------------
// request | start, busy, in_req (req_t)  | beat taken on clk edge with start & !busy
// result  | out_valid, out_rsp (rsp_t)   | one-cycle strobe, taken on the next edge
//
// Flow: the FNV unit hashes a request's key one byte a cycle, then the slot RAM is
// probed one slot a cycle through its read port. A request of unknown kind is
// answered without hashing or probing, and busy stays low for it.
// Reset: synchronous, active low. Afterwards a clearing pass writes every slot empty,
// one slot a cycle, with busy high.
// The result strobe cannot be stalled; for a known kind, busy stays high from accept to result.
module hash_table_linear_probe_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  htlp_pkg::req_t in_req,
  output logic           out_valid,
  output htlp_pkg::rsp_t out_rsp
);
  import htlp_pkg::*;

  // sequencer state
  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [63:0]      key_r, key_nxt;      // normalised key
  logic [63:0]      val_r, val_nxt;      // normalised value
  logic [IDX_W-1:0] idx_r, idx_nxt;      // probe slot, also the clear pointer
  logic [IDX_W-1:0] probe_r, probe_nxt;  // probes done so far
  logic             have_tomb_r, have_tomb_nxt;
  logic [IDX_W-1:0] tomb_r, tomb_nxt;    // first tombstone met
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_rsp_r, out_rsp_nxt;

  // hash unit
  logic             hash_kick;
  logic             hash_done;
  logic [IDX_W-1:0] hash_slot;

  // slot RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  slot_t            ram_rdata;

  // probe decode
  logic             key_hit;
  logic             last_probe;
  logic             tomb_here;
  logic [IDX_W-1:0] idx_inc;

  htlp_fnv u_fnv (
    .clk   (clk),
    .rst_n (rst_n),
    .kick  (hash_kick),
    .key   (key_nxt),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  htlp_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign key_hit    = (ram_rdata.st == ST_OCC) && (ram_rdata.key == key_r);
  assign last_probe = (probe_r == IDX_MAX);
  assign tomb_here  = (ram_rdata.st == ST_TOMB);
  assign idx_inc    = IDX_W'(idx_r + 1'b1);   // wraps at the table end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    have_tomb_nxt = have_tomb_r;
    tomb_nxt      = tomb_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    hash_kick     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '{st: ST_OCC, key: key_r, val: val_r};
    ram_raddr     = idx_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '{st: ST_EMPTY, key: '0, val: '0};
        idx_nxt   = idx_inc;
        if (idx_r == IDX_MAX) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          op_nxt        = in_req.op;
          key_nxt       = as_str(in_req.key);
          val_nxt       = as_str(in_req.value);
          probe_nxt     = '0;
          have_tomb_nxt = 1'b0;
          if (in_req.op == OP_SET || in_req.op == OP_GET || in_req.op == OP_DEL) begin
            hash_kick = 1'b1;
            state_nxt = S_HASH;
          end else begin
            // unknown kind: nothing changes, answer at once
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{status: STS_ABSENT, read_value: '0, entry_count: cnt_r};
          end
        end
      end

      S_HASH: begin
        if (hash_done) begin
          idx_nxt   = hash_slot;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        // read of the home slot is issued here
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        // default: go on to the next slot, reading it now
        idx_nxt   = idx_inc;
        probe_nxt = IDX_W'(probe_r + 1'b1);
        ram_raddr = idx_inc;
        out_rsp_nxt = '{status: STS_ABSENT, read_value: '0, entry_count: cnt_r};

        if (op_r == OP_SET) begin
          if (key_hit) begin
            ram_we                 = 1'b1;
            out_rsp_nxt.status     = STS_HIT;
            state_nxt              = S_IDLE;
          end else if (ram_rdata.st == ST_EMPTY) begin
            ram_we                 = 1'b1;
            ram_waddr              = have_tomb_r ? tomb_r : idx_r;
            cnt_nxt                = CNT_W'(cnt_r + 1'b1);
            out_rsp_nxt.status     = STS_NEW;
            state_nxt              = S_IDLE;
          end else if (last_probe) begin
            // whole table walked: reuse the first tombstone, else drop
            if (have_tomb_r || tomb_here) begin
              ram_we               = 1'b1;
              ram_waddr            = have_tomb_r ? tomb_r : idx_r;
              cnt_nxt              = CNT_W'(cnt_r + 1'b1);
              out_rsp_nxt.status   = STS_NEW;
            end else begin
              out_rsp_nxt.status   = STS_FULL;
            end
            state_nxt              = S_IDLE;
          end else if (tomb_here && !have_tomb_r) begin
            have_tomb_nxt          = 1'b1;
            tomb_nxt               = idx_r;
          end
        end else begin
          if (ram_rdata.st == ST_EMPTY) begin
            state_nxt              = S_IDLE;
          end else if (key_hit) begin
            out_rsp_nxt.status     = STS_HIT;
            if (op_r == OP_GET) begin
              out_rsp_nxt.read_value = ram_rdata.val;
            end else begin
              ram_we               = 1'b1;
              ram_wdata            = '{st: ST_TOMB, key: ram_rdata.key, val: ram_rdata.val};
              cnt_nxt              = CNT_W'(cnt_r - 1'b1);
            end
            state_nxt              = S_IDLE;
          end else if (last_probe) begin
            state_nxt              = S_IDLE;
          end
        end

        if (state_nxt == S_IDLE) begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.entry_count = cnt_nxt;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      have_tomb_r <= 1'b0;
      probe_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      have_tomb_r <= have_tomb_nxt;
      probe_r     <= probe_nxt;
    end
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    tomb_r    <= tomb_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

@@ sv/htlp_chk.sv @@
`timescale 1ns / 1ps

module htlp_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input htlp_pkg::rsp_t out_rsp
);
  import htlp_pkg::*;

  // accepted request either holds the block busy or is answered at once
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  // a result is given only once the block is idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // out of reset the block is busy clearing and gives no result
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_valid))
    else $error("not busy after reset");

  // nonzero read data only on a hit
  a_rv_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.read_value != '0) |-> (out_rsp.status == STS_HIT))
    else $error("read value without hit");

  // a dropped set means every slot is occupied
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == STS_FULL) |->
      (out_rsp.entry_count == CNT_W'(TABLE_DEPTH)))
    else $error("table full reported with free slots");

endmodule

bind hash_table_linear_probe_top htlp_chk u_htlp_chk (.*);

@@ test/htlp_table_checker.sv @@
`timescale 1ns / 1ps

module htlp_table_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  htlp_pkg::req_t in_req,
  input  logic           out_valid,
  input  htlp_pkg::rsp_t out_rsp,
  output int             error_count,
  output int             pending_rsps
);
  import htlp_pkg::*;

  localparam logic [63:0] FNV_MULT = 64'd1099511628211;

  slot_st_t    slot_kind  [TABLE_DEPTH];
  logic [63:0] slot_key   [TABLE_DEPTH];
  logic [63:0] slot_val   [TABLE_DEPTH];
  int          occ;
  int          errors;
  rsp_t        expected_rsps [$];

  // bytes up to the first NUL, zero beyond
  function automatic logic [63:0] norm_string(input logic [63:0] x);
    logic [63:0] r;
    int          b;
    r = '0;
    b = 0;
    while (b < 8 && x[8*b +: 8] != 8'h00) begin
      r[8*b +: 8] = x[8*b +: 8];
      b++;
    end
    return r;
  endfunction

  function automatic int unsigned home_of(input logic [63:0] k);
    logic [63:0] h;
    int          b;
    h = FNV_BASIS;
    b = 0;
    while (b < 8 && k[8*b +: 8] != 8'h00) begin
      h = (h ^ {56'd0, k[8*b +: 8]}) * FNV_MULT;
      b++;
    end
    return 32'(h % 64'(TABLE_DEPTH));
  endfunction

  task automatic claim_slot(input int unsigned at, input logic [63:0] k, input logic [63:0] v);
    slot_kind[at] = ST_OCC;
    slot_key[at]  = k;
    slot_val[at]  = v;
    occ++;
  endtask

  task automatic apply_request(input req_t r, output rsp_t e);
    logic [63:0] k;
    logic [63:0] v;
    int unsigned idx;
    int unsigned tomb_idx;
    bit          have_tomb;
    bit          done;
    e         = '0;
    k         = norm_string(r.key);
    v         = norm_string(r.value);
    idx       = home_of(k);
    tomb_idx  = 0;
    have_tomb = 1'b0;
    done      = 1'b0;
    case (r.op)
      OP_SET: begin
        for (int p = 0; p < TABLE_DEPTH && !done; p++) begin
          if (slot_kind[idx] == ST_OCC && slot_key[idx] == k) begin
            slot_val[idx] = v;
            e.status      = STS_HIT;
            done          = 1'b1;
          end else if (slot_kind[idx] == ST_TOMB) begin
            if (!have_tomb) begin
              have_tomb = 1'b1;
              tomb_idx  = idx;
            end
          end else if (slot_kind[idx] == ST_EMPTY) begin
            claim_slot(have_tomb ? tomb_idx : idx, k, v);
            e.status = STS_NEW;
            done     = 1'b1;
          end
          idx = (idx + 1) % TABLE_DEPTH;
        end
        // whole table walked: reuse a tombstone or drop
        if (!done) begin
          if (have_tomb) begin
            claim_slot(tomb_idx, k, v);
            e.status = STS_NEW;
          end else begin
            e.status = STS_FULL;
          end
        end
      end
      OP_GET, OP_DEL: begin
        for (int p = 0; p < TABLE_DEPTH && !done; p++) begin
          if (slot_kind[idx] == ST_EMPTY) begin
            done = 1'b1;
          end else if (slot_kind[idx] == ST_OCC && slot_key[idx] == k) begin
            e.status = STS_HIT;
            if (r.op == OP_GET) begin
              e.read_value = slot_val[idx];
            end else begin
              slot_kind[idx] = ST_TOMB;
              occ--;
            end
            done = 1'b1;
          end
          idx = (idx + 1) % TABLE_DEPTH;
        end
      end
      default: ;
    endcase
    e.entry_count = CNT_W'(occ);
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_kind[i] = ST_EMPTY;
      occ = 0;
      expected_rsps.delete();
    end else begin
      // result of an earlier beat first, then the beat taken at this edge
      if (out_valid === 1'b1) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status=%0d value=%h count=%0d",
                     out_rsp.status, out_rsp.read_value, out_rsp.entry_count);
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp.status !== want.status || out_rsp.read_value !== want.read_value ||
              out_rsp.entry_count !== want.entry_count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp sts=%0d val=%h cnt=%0d, got sts=%0d val=%h cnt=%0d",
                       want.status, want.read_value, want.entry_count,
                       out_rsp.status, out_rsp.read_value, out_rsp.entry_count);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        apply_request(in_req, want);
        expected_rsps.push_back(want);
      end
    end
    error_count  <= errors;
    pending_rsps <= expected_rsps.size();
  end

endmodule

@@ test/tb_hash_table_linear_probe_top.sv @@
`timescale 1ns / 1ps

module tb_hash_table_linear_probe_top;
  import htlp_pkg::*;

  // op code the block must ignore (answers absent, changes nothing)
  localparam logic [1:0] OP_NOP = 2'd3;

  // Slowest beat: hashing a full-length key, then a probe of every slot on a full
  // table. The clearing pass after reset and a sender gap can come on top of it.
  // The watchdog limit is chosen to exceed that lot.
  localparam int STALL_LIMIT  = 8192;
  localparam int TAIL_CYCLES  = 1100;  // longer than the slowest beat
  localparam int WARM_BEATS   = 400;   // sparse table
  localparam int DENSE_BEATS  = 350;   // tombstones pile up, longer probe chains
  localparam int STEADY_BEATS = 120;   // closing stretch, no sender gaps

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic start  = 1'b0;
  req_t in_req = '0;
  logic busy;
  logic out_valid;
  rsp_t out_rsp;

  int error_count;
  int pending_rsps;

  // every key ever written, so later gets and deletes can hit
  logic [63:0] stored_keys [$];

  always #6 clk = ~clk;

  hash_table_linear_probe_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  // Watches both channels, keeps its own copy of the table, and scores
  // each result strobe against the oldest outstanding prediction.
  htlp_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .error_count (error_count),
    .pending_rsps(pending_rsps)
  );

  // Present one beat and hold it until taken (start high, busy low at an
  // edge). Returns at the accepting edge, start still high, so a following
  // call simply overwrites in_req for the next beat.
  task automatic send_beat(input req_t r);
    start  <= 1'b1;
    in_req <= r;
    if (r.op == OP_SET) stored_keys.push_back(r.key);
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Random sender gap with start low, roughly one beat in four.
  task automatic maybe_pause(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic request(input logic [1:0] op, input logic [63:0] k, input logic [63:0] v);
    send_beat('{op, k, v});
    maybe_pause(1'b1);
  endtask

  // Drop start and wait until every outstanding result has been scored.
  // It first waits on the clock, so the beat just taken is counted as outstanding.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsps != 0) @(posedge clk);
  endtask

  // len non-NUL bytes, NUL padded
  function automatic logic [63:0] random_key(input int len);
    logic [63:0] k;
    k = '0;
    for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   len;
    pick = $urandom_range(0, 99);
    r.op = pick < 40 ? OP_SET : pick < 75 ? OP_GET : pick < 95 ? OP_DEL : OP_NOP;
    pick = $urandom_range(0, 99);
    if (pick < 60 && stored_keys.size() != 0) begin
      r.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      // same key seen through junk after its terminator
      if ($urandom_range(0, 3) == 0) begin
        len = 0;
        while (len < 8 && r.key[8*len +: 8] != 8'h00) len++;
        for (int b = len + 1; b < 8; b++) r.key[8*b +: 8] = 8'($urandom);
      end
    end else if (pick < 80) begin
      r.key = random_key($urandom_range(0, 8));
    end else begin
      r.key = {$urandom, $urandom};
    end
    r.value = {$urandom, $urandom};
    // a NUL inside the value truncates what is stored
    if ($urandom_range(0, 4) == 0) r.value[8*$urandom_range(0, 7) +: 8] = 8'h00;
    return r;
  endfunction

  task automatic random_phase(input int beats, input bit gaps);
    for (int i = 0; i < beats; i++) begin
      send_beat(random_request());
      maybe_pause(gaps);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats. The first one also sits out the clearing pass.
    request(OP_GET, 64'h4141, 64'h0);                       // empty table: absent
    request(OP_DEL, 64'h4141, 64'h0);                       // nothing to remove
    request(OP_SET, 64'h0, '1);                             // empty key is a real key
    request(OP_GET, 64'hFFFF_FFFF_FFFF_FF00, 64'h0);        // empty key, junk behind NUL
    request(OP_SET, 64'hDEAD_BEEF_0000_4141, 64'h1122_0033_4455_6677); // "AA", value cut
    request(OP_GET, 64'h4141, 64'h0);
    request(OP_SET, 64'h4141, 64'h0);                       // update to empty value
    request(OP_GET, 64'h4141, 64'h0);
    request(OP_SET, '1, 64'h8000_0000_0000_0001);           // full-length key
    request(OP_SET, 64'h01, 64'h7FFF_FFFF_FFFF_FFFF);       // one-byte key
    request(OP_NOP, '1, '1);                                // ignored op
    request(OP_GET, '1, 64'h0);
    request(OP_DEL, 64'h4141, 64'h0);                       // leaves a tombstone
    request(OP_GET, 64'h4141, 64'h0);
    request(OP_DEL, 64'h4141, 64'h0);                       // already gone
    request(OP_SET, 64'h4141, 64'hA5);                      // reinsert over the tombstone
    request(OP_DEL, 64'h0, '1);
    request(OP_GET, 64'h01, 64'h0);
    request(OP_NOP, 64'h0, 64'h0);

    random_phase(WARM_BEATS, 1'b1);
    drain();

    // More traffic with tombstones building up, then a closing stretch without gaps.
    random_phase(DENSE_BEATS - STEADY_BEATS, 1'b1);
    random_phase(STEADY_BEATS, 1'b0);

    drain();
    // catch any stray strobe after the last expected beat
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_rsps == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Counts cycles in which neither channel moves a beat.
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/htlp_pkg.sv
sv/htlp_ram.sv
sv/htlp_fnv.sv
sv/hash_table_linear_probe_top.sv
sv/htlp_chk.sv
test/htlp_table_checker.sv
test/tb_hash_table_linear_probe_top.sv
